// File: design/nws_pkg.sv
package nws_pkg;

   localparam int SAMPLE_RATE_DEF     = 44100;
   localparam int PHASE_BITS_DEF      = 32;
   localparam int SINE_TABLE_BITS_DEF = 10;

   localparam int WAVE_W  = 3;
   localparam int AMP_W   = 15;
   localparam int SPB_W   = 22;
   localparam int LEFT_W  = 28;
   localparam int LFSR_W  = 16;
   localparam int VAL_W   = 32;
   localparam int SINE_W  = 31;
   localparam int PROD_W  = 48;
   localparam int CSR_A_W = 2;

   localparam logic [CSR_A_W-1:0] CSR_WAVE_SELECT     = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_AMPLITUDE_SCALE = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_SAMPLES_PER_BEAT = 2'd2;

   typedef enum logic [WAVE_W-1:0] {
      WAVE_SINE     = 3'd0,
      WAVE_SQUARE   = 3'd1,
      WAVE_TRIANGLE = 3'd2,
      WAVE_SAWTOOTH = 3'd3,
      WAVE_NOISE    = 3'd4
   } wave_type;

   typedef enum logic {
      ACTION_NOTE = 1'b0,
      ACTION_TICK = 1'b1
   } action_type;

   localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd32767;
   localparam logic [SPB_W-1:0]  SPB_RESET  = 22'd22050;
   localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
   localparam logic [3:0]        SEMI_MAX   = 4'd11;
   localparam logic [3:0]        OCT_MAX    = 4'd8;
   localparam int                NUM_SEMI   = 12;
   localparam int                NUM_OCT    = 9;
   localparam int                STEP_DEN_SHIFT = 24;
   localparam longint unsigned   PHASE_INIT32   = 64'd21426132;

   localparam logic signed [VAL_W-1:0] Q30_POS = 32'sh4000_0000;
   localparam logic signed [VAL_W-1:0] Q30_NEG = 32'shC000_0000;
   localparam logic [VAL_W-1:0]        HALF_TURN = 32'h8000_0000;
   localparam longint                  Q30_ONE = 64'sd1073741824;

   // octave-8 note frequencies, Q16.16 Hz
   localparam logic [31:0] NOTE_ROM [NUM_SEMI] = '{
      32'd274334289, 32'd290647054, 32'd307929828, 32'd326240288,
      32'd345639545, 32'd366192342, 32'd387967272, 32'd411037006,
      32'd435478539, 32'd461373440, 32'd488808132, 32'd517874176
   };

   localparam longint SIN_COEF [6] = '{
      64'sd1686629713, -64'sd693598668, 64'sd85569306,
      -64'sd5026996, 64'sd172272, -64'sd3864
   };

   typedef struct packed {
      logic                    is_sine;
      logic                    neg;
      logic signed [VAL_W-1:0] v_other;
      logic [AMP_W-1:0]        amp;
      logic                    note_end;
   } nws_issue_type;

   // quarter-wave sine entry in Q30, elaboration only
   function automatic longint quarter_sine(input longint k, input int table_bits);
      longint x;
      longint y;
      longint p;
      x = ((k << 1) + 64'sd1) << (29 - table_bits);
      y = (x * x) / Q30_ONE;
      p = SIN_COEF[5];
      for (int i = 4; i >= 0; i--) begin
         p = SIN_COEF[i] + (p * y) / Q30_ONE;
      end
      p = (p * x) / Q30_ONE;
      if (p < 0) p = 0;
      if (p > Q30_ONE) p = Q30_ONE;
      return p;
   endfunction

endpackage

// File: design/note_waveform_synth.sv
// Note waveform synthesizer (phase-accumulator oscillator).
// req_* stream: tuser = action (0 start note, 1 sample tick); tdata holds
//   semitone, octave and length code. A note word loads the phase step and
//   the note's sample count; it produces no output word.
// rsp_* stream: tdata = signed sample, tlast = last sample of the note.
//   One rsp word per tick word while the note still has samples left.
// csr_*: write-only registers (0 wave select, 1 amplitude, 2 samples/beat),
//   to be written while the stream is idle; the block itself does not enforce it.
// A tick's sample passes the sine ROM read, the multiply and the output
//   register in that order before it shows on rsp.
// Throughput: one word per cycle while rsp is not stalled; oscillator state
//   updates in the accept cycle, so ticks may arrive back to back.
// Reset (synchronous): registers to defaults, no note playing, phase and
//   noise generator to their start values. No clearing pass.
// A stalled rsp fills the three stages; req_tready drops only once all are
//   occupied and resumes as soon as the output word is taken.
module note_waveform_synth import nws_pkg::*; #(
   parameter int SAMPLE_RATE     = SAMPLE_RATE_DEF,
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [SPB_W-1:0]   csr_wdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,  // semitone[3:0], octave[7:4], length_code[11:8]
   input  logic               req_tuser,  // action
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic signed [15:0] rsp_tdata,  // sample[15:0]
   output logic               rsp_tlast
);

   logic                       issue_valid;
   nws_issue_type              issue;
   logic [SINE_TABLE_BITS-1:0] rom_addr;
   logic [SINE_W-1:0]          rom_data;

   nws_osc #(
      .SAMPLE_RATE     (SAMPLE_RATE),
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_osc (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .issue_valid (issue_valid),
      .issue       (issue),
      .rom_addr    (rom_addr)
   );

   nws_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (req_tready),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   nws_out u_out (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue       (issue),
      .rom_data    (rom_data),
      .in_ready    (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// File: design/nws_sine_rom.sv
module nws_sine_rom import nws_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [SINE_TABLE_BITS-1:0] rd_addr,
   output logic [SINE_W-1:0]          rd_data
);

   localparam int ENTRIES = 1 << SINE_TABLE_BITS;

   typedef logic [SINE_W-1:0] rom_type [ENTRIES];

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k < ENTRIES; k++) begin
         r[k] = SINE_W'(quarter_sine(longint'(k), SINE_TABLE_BITS));
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [SINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/nws_osc.sv
module nws_osc import nws_pkg::*; #(
   parameter int SAMPLE_RATE     = SAMPLE_RATE_DEF,
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_A_W-1:0]         csr_addr,
   input  logic [SPB_W-1:0]           csr_wdata,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [15:0]                req_tdata,
   input  logic                       req_tuser,
   output logic                       issue_valid,
   output nws_issue_type              issue,
   output logic [SINE_TABLE_BITS-1:0] rom_addr
);

   localparam longint unsigned HALF =
      (64'd1 << (32 - PHASE_BITS)) >> 1;
   localparam longint unsigned PHASE_INIT_L =
      (PHASE_INIT32 + HALF) >> (32 - PHASE_BITS);
   localparam logic [PHASE_BITS-1:0] PHASE_INIT = PHASE_INIT_L[PHASE_BITS-1:0];

   // phase increment per semitone and octave
   logic [PHASE_BITS-1:0] step_table [NUM_SEMI][NUM_OCT];

   for (genvar s = 0; s < NUM_SEMI; s++) begin : g_semi
      for (genvar o = 0; o < NUM_OCT; o++) begin : g_oct
         localparam longint unsigned NUM = 64'(NOTE_ROM[s]) << PHASE_BITS;
         localparam longint unsigned DEN =
            64'(2 * SAMPLE_RATE) << (STEP_DEN_SHIFT - o);
         localparam longint unsigned STEP = (NUM + DEN / 2) / DEN;
         assign step_table[s][o] = STEP[PHASE_BITS-1:0];
      end
   end

   wave_type              wave_ff;
   logic [AMP_W-1:0]      amp_ff;
   logic [SPB_W-1:0]      spb_ff;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] step_ff, step_in;
   logic [LEFT_W-1:0]     left_ff, left_in;
   logic [LFSR_W-1:0]     lfsr_ff, lfsr_in;

   logic                  accept;
   logic                  has_samples;
   logic [3:0]            semi;
   logic [3:0]            oct;
   logic [3:0]            len_code;
   logic [VAL_W-1:0]      t32;
   logic [1:0]            quad;
   logic [SINE_TABLE_BITS-1:0] idx;

   assign accept      = req_tvalid && req_tready;
   assign has_samples = (left_ff != '0);
   assign issue_valid = accept && (req_tuser == ACTION_TICK) && has_samples;

   assign semi     = (req_tdata[3:0] > SEMI_MAX) ? SEMI_MAX : req_tdata[3:0];
   assign oct      = (req_tdata[7:4] > OCT_MAX) ? OCT_MAX : req_tdata[7:4];
   assign len_code = req_tdata[11:8];

   assign t32  = VAL_W'(phase_ff) << (32 - PHASE_BITS);
   assign quad = phase_ff[PHASE_BITS-1 -: 2];
   assign idx  = phase_ff[PHASE_BITS-3 -: SINE_TABLE_BITS];
   assign rom_addr = quad[0] ? ~idx : idx;

   always_comb begin
      issue.is_sine  = (wave_ff == WAVE_SINE);
      issue.neg      = quad[1];
      issue.amp      = amp_ff;
      issue.note_end = (left_ff == LEFT_W'(1));
      case (wave_ff)
         WAVE_SINE: begin
            issue.v_other = '0;
         end
         WAVE_SQUARE: begin
            issue.v_other = t32[31] ? Q30_NEG : Q30_POS;
         end
         WAVE_TRIANGLE: begin
            if (t32[31] != t32[30]) issue.v_other = HALF_TURN - t32;
            else                    issue.v_other = t32;
         end
         WAVE_SAWTOOTH: begin
            issue.v_other = {t32[31], t32[31:1]};
         end
         default: begin
            issue.v_other = {~lfsr_ff[15], ~lfsr_ff[15], lfsr_ff[14:0], 15'b0};
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      left_in  = left_ff;
      lfsr_in  = lfsr_ff;
      if (accept) begin
         if (req_tuser == ACTION_NOTE) begin
            step_in = step_table[semi][oct];
            left_in = LEFT_W'({spb_ff, 6'b0} >> len_code);
         end else if (has_samples) begin
            phase_in = phase_ff + step_ff;
            left_in  = left_ff - LEFT_W'(1);
            lfsr_in  = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff  <= WAVE_SINE;
         amp_ff   <= AMP_RESET;
         spb_ff   <= SPB_RESET;
         phase_ff <= PHASE_INIT;
         step_ff  <= '0;
         left_ff  <= '0;
         lfsr_ff  <= LFSR_SEED;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         left_ff  <= left_in;
         lfsr_ff  <= lfsr_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_WAVE_SELECT:      wave_ff <= wave_type'(csr_wdata[WAVE_W-1:0]);
               CSR_AMPLITUDE_SCALE:  amp_ff  <= csr_wdata[AMP_W-1:0];
               CSR_SAMPLES_PER_BEAT: spb_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// File: design/nws_out.sv
module nws_out import nws_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     issue_valid,
   input  nws_issue_type            issue,
   input  logic [SINE_W-1:0]        rom_data,
   output logic                     in_ready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic signed [15:0]       rsp_tdata,
   output logic                     rsp_tlast
);

   localparam logic signed [PROD_W-1:0] TRUNC_BIAS = 48'sh0000_3FFF_FFFF;

   logic                       s1_valid_ff;
   nws_issue_type              s1_ff;
   logic                       s2_valid_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       s2_end_ff;
   logic                       out_valid_ff;
   logic signed [15:0]         sample_ff;
   logic                       last_ff;

   logic                       adv_out;
   logic                       adv2;
   logic                       adv1;
   logic signed [VAL_W-1:0]    sine_val;
   logic signed [VAL_W-1:0]    wave_val;
   logic signed [PROD_W-1:0]   prod_adj;

   assign adv_out  = !out_valid_ff || rsp_tready;
   assign adv2     = !s2_valid_ff || adv_out;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   assign sine_val = s1_ff.neg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
   assign wave_val = s1_ff.is_sine ? sine_val : s1_ff.v_other;
   assign prod_in  = wave_val * $signed({1'b0, s1_ff.amp});

   // divide by 2^30, rounding toward zero
   assign prod_adj = prod_ff + (prod_ff[PROD_W-1] ? TRUNC_BIAS : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv1)    s1_valid_ff  <= issue_valid;
         if (adv2)    s2_valid_ff  <= s1_valid_ff;
         if (adv_out) out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= issue;
      end
      if (adv2) begin
         prod_ff   <= prod_in;
         s2_end_ff <= s1_ff.note_end;
      end
      if (adv_out) begin
         sample_ff <= prod_adj[45:30];
         last_ff   <= s2_end_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = sample_ff;
   assign rsp_tlast  = last_ff;

endmodule
